### src/aavr_pkg.sv
`default_nettype none

package aavr_pkg;

    // default parameter values
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // fixed-point formats
    localparam int FRAC_BITS  = 30;   // Q1.30 for unit axis, sine, cosine
    localparam int QUOT_BITS  = 31;   // unit component magnitude, bits 30..0
    localparam int CS_WIDTH   = 34;   // CORDIC x, y, z datapath
    localparam int UNIT_WIDTH = 32;   // unit axis, sine, cosine
    localparam int MAT_WIDTH  = 34;   // rotation matrix entries

    localparam logic signed [CS_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CS_WIDTH-1:0] FX_ONE      = 34'sd1073741824;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CS_WIDTH-1:0] atan_turns(input int idx);
        logic signed [CS_WIDTH-1:0] val;
        case (idx)
            0:  val = 34'sd536870912;
            1:  val = 34'sd316933406;
            2:  val = 34'sd167458907;
            3:  val = 34'sd85004756;
            4:  val = 34'sd42667331;
            5:  val = 34'sd21354465;
            6:  val = 34'sd10679838;
            7:  val = 34'sd5340245;
            8:  val = 34'sd2670163;
            9:  val = 34'sd1335087;
            10: val = 34'sd667544;
            11: val = 34'sd333772;
            12: val = 34'sd166886;
            13: val = 34'sd83443;
            14: val = 34'sd41722;
            15: val = 34'sd20861;
            16: val = 34'sd10430;
            17: val = 34'sd5215;
            18: val = 34'sd2608;
            19: val = 34'sd1304;
            20: val = 34'sd652;
            21: val = 34'sd326;
            22: val = 34'sd163;
            23: val = 34'sd81;
            24: val = 34'sd41;
            25: val = 34'sd20;
            26: val = 34'sd10;
            27: val = 34'sd5;
            28: val = 34'sd3;
            29: val = 34'sd1;
            30: val = 34'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### src/axis_angle_vector_rotate.sv
// The square root chain (one root bit per cell) and the divider chain (31
// quotient bits, one per cell) lie in series between input accept and m_tvalid,
// plus matrix and multiply stages. A two-entry output buffer parts the channels.
// Throughput: one item per cycle while the output buffer is not full.
// Reset: synchronous active-low aresetn empties the pipeline and output buffer.
`default_nettype none

module axis_angle_vector_rotate #(
    parameter int COORD_WIDTH  = aavr_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = aavr_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF,
    localparam int IN_TDATA_W  = ((6*COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((3*COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_turns
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_x, out_y, out_z
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // zero_axis
    output logic                        m_tuser
);

    localparam int CWE   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int AWE   = (ANGLE_WIDTH > 32) ? 32 : ANGLE_WIDTH;
    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int RW    = CWE + 1;
    localparam int SQW   = 2 * RW;
    localparam int QB    = aavr_pkg::QUOT_BITS;
    localparam int FRAC  = aavr_pkg::FRAC_BITS;
    localparam int CSW   = aavr_pkg::CS_WIDTH;
    localparam int UW    = aavr_pkg::UNIT_WIDTH;
    localparam int MW    = aavr_pkg::MAT_WIDTH;
    localparam int TW    = CWE + 4;
    localparam int SW    = CWE + 6;
    localparam int LAST  = RW + 38;

    typedef struct packed {
        logic [CWE-1:0] z;
        logic [CWE-1:0] y;
        logic [CWE-1:0] x;
        logic           zero;
    } res_t;

    logic en;
    logic accept;
    logic push;
    logic pop;
    logic [LAST:0] vld_reg;
    logic [1:0]    cnt_reg, cnt_next;
    res_t          slot0_reg, slot1_reg, res_new;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign push     = en && vld_reg[LAST];
    assign pop      = m_tvalid && m_tready;

    // stage 0: input registers
    logic signed [CWE-1:0] vec0_reg  [3];
    logic signed [CWE-1:0] axis0_reg [3];
    logic [AWE-1:0]        ang0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                vec0_reg[i]  <= s_tdata[i*COORD_WIDTH +: CWE];
                axis0_reg[i] <= s_tdata[(i+3)*COORD_WIDTH +: CWE];
            end
            ang0_reg <= s_tdata[6*COORD_WIDTH +: AWE];
        end
    end

    // stage 1: magnitudes, squares, angle fold
    logic [CWE-1:0]   mag0 [3];
    logic [2*CWE-1:0] sq0  [3];
    logic [31:0]      ph0, ph0_up, ph0_adj;
    logic             flip0;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag0[i] = axis0_reg[i][CWE-1] ? (~axis0_reg[i] + 1'b1) : axis0_reg[i];
            sq0[i]  = mag0[i] * mag0[i];
        end
        ph0     = 32'(ang0_reg) << (32 - AWE);
        ph0_up  = ph0 + 32'h4000_0000;
        flip0   = ph0_up[31];
        ph0_adj = ph0 ^ {flip0, 31'b0};
    end

    logic [2*CWE-1:0]      sq1_reg [3];
    logic [3*CWE-1:0]      mag1_reg;
    logic [2:0]            sgn1_reg;
    logic                  zero1_reg;
    logic signed [CSW-1:0] z1_reg;
    logic                  flip1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq1_reg[i]               <= sq0[i];
                mag1_reg[i*CWE +: CWE]   <= mag0[i];
                sgn1_reg[i]              <= axis0_reg[i][CWE-1];
            end
            zero1_reg <= (axis0_reg[0] == '0) && (axis0_reg[1] == '0)
                         && (axis0_reg[2] == '0);
            z1_reg    <= CSW'($signed(ph0_adj));
            flip1_reg <= flip0;
        end
    end

    // stage 2: sum of squares
    logic [SQW-1:0] sumsq2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sumsq2_reg <= SQW'(sq1_reg[0]) + SQW'(sq1_reg[1]) + SQW'(sq1_reg[2]);
        end
    end

    // square root chain, one root bit per cell
    logic [SQW-1:0]  sv_w    [RW+1];
    logic [RW+1:0]   srem_w  [RW+1];
    logic [RW-1:0]   sroot_w [RW+1];

    assign sv_w[0]    = sumsq2_reg;
    assign srem_w[0]  = '0;
    assign sroot_w[0] = '0;

    for (genvar c = 0; c < RW; c++) begin : g_sqrt
        aavr_sqrt_cell #(
            .ROOT_WIDTH (RW),
            .BIT_POS    (RW - 1 - c)
        ) u_cell (
            .aclk     (aclk),
            .en       (en),
            .v_in     (sv_w[c]),
            .rem_in   (srem_w[c]),
            .root_in  (sroot_w[c]),
            .v_out    (sv_w[c+1]),
            .rem_out  (srem_w[c+1]),
            .root_out (sroot_w[c+1])
        );
    end

    // axis magnitudes meet the norm at the divider input
    logic [3*CWE-1:0] mag_d;

    aavr_delay #(.WIDTH(3*CWE), .DEPTH(RW + 1)) u_mag_dly (
        .aclk (aclk), .en (en), .din (mag1_reg), .dout (mag_d)
    );

    // three divider chains: magnitude * 2^30 / norm
    logic [RW-1:0] drem_w [3][QB+1];
    logic [RW-1:0] dd_w   [3][QB+1];
    logic [QB-1:0] dq_w   [3][QB+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign dd_w[l][0] = sroot_w[RW];
        assign dq_w[l][0] = '0;
        for (genvar c = 0; c < QB; c++) begin : g_div
            logic [RW:0] trial;
            if (c == 0) begin : g_first
                assign trial = (RW+1)'(mag_d[l*CWE +: CWE]);
            end else begin : g_next
                assign trial = {drem_w[l][c], 1'b0};
            end
            aavr_div_cell #(
                .DIV_WIDTH  (RW),
                .QUOT_WIDTH (QB)
            ) u_cell (
                .aclk     (aclk),
                .en       (en),
                .trial_in (trial),
                .d_in     (dd_w[l][c]),
                .q_in     (dq_w[l][c]),
                .rem_out  (drem_w[l][c+1]),
                .d_out    (dd_w[l][c+1]),
                .q_out    (dq_w[l][c+1])
            );
        end
    end

    // signed unit axis
    logic [2:0] sgn_d;

    aavr_delay #(.WIDTH(3), .DEPTH(RW + 32)) u_sgn_dly (
        .aclk (aclk), .en (en), .din (sgn1_reg), .dout (sgn_d)
    );

    logic signed [UW-1:0] n_reg [3];
    logic signed [UW-1:0] qs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qs[i] = $signed(UW'(dq_w[i][QB]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= sgn_d[i] ? -qs[i] : qs[i];
            end
        end
    end

    // CORDIC chain for cosine and sine
    logic signed [CSW-1:0] cx_w [STEPS+1];
    logic signed [CSW-1:0] cy_w [STEPS+1];
    logic signed [CSW-1:0] cz_w [STEPS+1];
    logic                  cf_w [STEPS+1];

    assign cx_w[0] = aavr_pkg::CORDIC_GAIN;
    assign cy_w[0] = '0;
    assign cz_w[0] = z1_reg;
    assign cf_w[0] = flip1_reg;

    for (genvar c = 0; c < STEPS; c++) begin : g_cordic
        aavr_cordic_cell #(.SHIFT(c)) u_cell (
            .aclk     (aclk),
            .en       (en),
            .x_in     (cx_w[c]),
            .y_in     (cy_w[c]),
            .z_in     (cz_w[c]),
            .flip_in  (cf_w[c]),
            .x_out    (cx_w[c+1]),
            .y_out    (cy_w[c+1]),
            .z_out    (cz_w[c+1]),
            .flip_out (cf_w[c+1])
        );
    end

    // clamp to unit range and undo the half-turn fold
    logic signed [CSW-1:0] xc, yc;
    logic [2*UW-1:0]       cs_reg, cs_d;

    always_comb begin
        xc = cx_w[STEPS];
        yc = cy_w[STEPS];
        if (xc > aavr_pkg::FX_ONE)  xc = aavr_pkg::FX_ONE;
        if (xc < -aavr_pkg::FX_ONE) xc = -aavr_pkg::FX_ONE;
        if (yc > aavr_pkg::FX_ONE)  yc = aavr_pkg::FX_ONE;
        if (yc < -aavr_pkg::FX_ONE) yc = -aavr_pkg::FX_ONE;
        if (cf_w[STEPS]) begin
            xc = -xc;
            yc = -yc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cs_reg <= {UW'(yc), UW'(xc)};
        end
    end

    aavr_delay #(.WIDTH(2*UW), .DEPTH(RW + 32 - STEPS)) u_cs_dly (
        .aclk (aclk), .en (en), .din (cs_reg), .dout (cs_d)
    );

    // vector and zero flag travel to the matrix stages
    logic [3*CWE-1:0] vec0_pk, vec_d;
    logic             zero_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vec0_pk[i*CWE +: CWE] = vec0_reg[i];
        end
    end

    aavr_delay #(.WIDTH(3*CWE), .DEPTH(RW + 34)) u_vec_dly (
        .aclk (aclk), .en (en), .din (vec0_pk), .dout (vec_d)
    );

    aavr_delay #(.WIDTH(1), .DEPTH(RW + 33)) u_zero_dly (
        .aclk (aclk), .en (en), .din (zero1_reg), .dout (zero_d)
    );

    // M1: axis products, 1 - cos
    logic signed [UW-1:0]   c_t, s_t;
    logic signed [2*UW-1:0] mul_nsq [3];
    logic signed [2*UW-1:0] mul_nn  [3];

    always_comb begin
        c_t = $signed(cs_d[UW-1:0]);
        s_t = $signed(cs_d[2*UW-1:UW]);
        for (int i = 0; i < 3; i++) begin
            mul_nsq[i] = n_reg[i] * n_reg[i];
        end
        mul_nn[0] = n_reg[0] * n_reg[1];
        mul_nn[1] = n_reg[0] * n_reg[2];
        mul_nn[2] = n_reg[1] * n_reg[2];
    end

    logic signed [UW-1:0] nsq_m1 [3];
    logic signed [UW-1:0] nn_m1  [3];
    logic signed [UW-1:0] n_m1   [3];
    logic signed [UW:0]   c1_m1;
    logic signed [UW-1:0] c_m1, s_m1;
    logic [3*CWE-1:0]     vec_m1;
    logic                 zero_m1;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nsq_m1[i] <= UW'(mul_nsq[i] >>> FRAC);
                nn_m1[i]  <= UW'(mul_nn[i] >>> FRAC);
                n_m1[i]   <= n_reg[i];
            end
            c1_m1   <= 33'sd1073741824 - (UW+1)'(c_t);
            c_m1    <= c_t;
            s_m1    <= s_t;
            vec_m1  <= vec_d;
            zero_m1 <= zero_d;
        end
    end

    // M2: terms scaled by cos, 1 - cos and sin
    logic signed [2*UW:0]   mul_p  [3];
    logic signed [UW-1:0]   dif_t  [3];
    logic signed [2*UW-1:0] mul_t  [3];
    logic signed [2*UW-1:0] mul_ns [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mul_p[i]  = nn_m1[i] * c1_m1;
            dif_t[i]  = 32'sd1073741824 - nsq_m1[i];
            mul_t[i]  = dif_t[i] * c_m1;
            mul_ns[i] = n_m1[i] * s_m1;
        end
    end

    logic signed [MW-1:0] p_m2   [3];
    logic signed [UW-1:0] t_m2   [3];
    logic signed [UW-1:0] ns_m2  [3];
    logic signed [UW-1:0] nsq_m2 [3];
    logic [3*CWE-1:0]     vec_m2;
    logic                 zero_m2;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_m2[i]   <= MW'(mul_p[i] >>> FRAC);
                t_m2[i]   <= UW'(mul_t[i] >>> FRAC);
                ns_m2[i]  <= UW'(mul_ns[i] >>> FRAC);
                nsq_m2[i] <= nsq_m1[i];
            end
            vec_m2  <= vec_m1;
            zero_m2 <= zero_m1;
        end
    end

    // M3: rotation matrix, entry r[row*3+col]
    logic signed [MW-1:0] r_m3 [9];
    logic [3*CWE-1:0]     vec_m3;
    logic                 zero_m3;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_m3[0] <= MW'(nsq_m2[0]) + MW'(t_m2[0]);
            r_m3[1] <= p_m2[0] + MW'(ns_m2[2]);
            r_m3[2] <= p_m2[1] - MW'(ns_m2[1]);
            r_m3[3] <= p_m2[0] - MW'(ns_m2[2]);
            r_m3[4] <= MW'(nsq_m2[1]) + MW'(t_m2[1]);
            r_m3[5] <= p_m2[2] + MW'(ns_m2[0]);
            r_m3[6] <= p_m2[1] + MW'(ns_m2[1]);
            r_m3[7] <= p_m2[2] - MW'(ns_m2[0]);
            r_m3[8] <= MW'(nsq_m2[2]) + MW'(t_m2[2]);
            vec_m3  <= vec_m2;
            zero_m3 <= zero_m2;
        end
    end

    // M4: vector times matrix entries
    logic signed [CWE+MW-1:0] mul_v [9];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mul_v[i*3+j] = $signed(vec_m3[i*CWE +: CWE]) * r_m3[i*3+j];
            end
        end
    end

    logic signed [TW-1:0] prod_m4 [9];
    logic [3*CWE-1:0]     vec_m4;
    logic                 zero_m4;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                prod_m4[k] <= TW'(mul_v[k] >>> FRAC);
            end
            vec_m4  <= vec_m3;
            zero_m4 <= zero_m3;
        end
    end

    // column sums, saturation, zero-axis bypass
    logic signed [SW-1:0] sum [3];
    logic [CWE-1:0]       sat [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sum[j] = SW'(prod_m4[j]) + SW'(prod_m4[3+j]) + SW'(prod_m4[6+j]);
            if ((sum[j][SW-1:CWE-1] == '0) || (sum[j][SW-1:CWE-1] == '1)) begin
                sat[j] = sum[j][CWE-1:0];
            end else if (sum[j][SW-1]) begin
                sat[j] = {1'b1, {(CWE-1){1'b0}}};
            end else begin
                sat[j] = {1'b0, {(CWE-1){1'b1}}};
            end
        end
        res_new.zero = zero_m4;
        res_new.x    = zero_m4 ? vec_m4[0 +: CWE]     : sat[0];
        res_new.y    = zero_m4 ? vec_m4[CWE +: CWE]   : sat[1];
        res_new.z    = zero_m4 ? vec_m4[2*CWE +: CWE] : sat[2];
    end

    // valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], accept};
        end
    end

    // two-entry output buffer
    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            slot0_reg <= res_new;
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                slot0_reg <= res_new;
            end else begin
                slot1_reg <= res_new;
            end
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = slot0_reg.zero;
    assign m_tdata  = OUT_TDATA_W'({COORD_WIDTH'(slot0_reg.z), COORD_WIDTH'(slot0_reg.y),
                                    COORD_WIDTH'(slot0_reg.x)});

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && cnt_reg == 2'd2))
        else $error("input stalled without full output buffer");

    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAST] && !en) |=> vld_reg[LAST])
        else $error("finished item lost during stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

### src/aavr_delay.sv
`default_nettype none

// shift line that carries side data alongside the arithmetic cells
module aavr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

### src/aavr_sqrt_cell.sv
`default_nettype none

// one root bit of a restoring integer square root
module aavr_sqrt_cell #(
    parameter int ROOT_WIDTH = 33,
    parameter int BIT_POS    = 0
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [2*ROOT_WIDTH-1:0] v_in,
    input  wire logic [ROOT_WIDTH+1:0]   rem_in,
    input  wire logic [ROOT_WIDTH-1:0]   root_in,
    output logic      [2*ROOT_WIDTH-1:0] v_out,
    output logic      [ROOT_WIDTH+1:0]   rem_out,
    output logic      [ROOT_WIDTH-1:0]   root_out
);

    logic [2*ROOT_WIDTH-1:0] v_reg;
    logic [ROOT_WIDTH+1:0]   rem_reg;
    logic [ROOT_WIDTH-1:0]   root_reg;
    logic [ROOT_WIDTH+3:0]   rem_sh;
    logic [ROOT_WIDTH+3:0]   trial;
    logic [ROOT_WIDTH+3:0]   diff;
    logic                    take;

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
        rem_sh = {rem_in, v_in[2*BIT_POS+1 -: 2]};
        trial  = {2'b00, root_in, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg    <= v_in;
            rem_reg  <= take ? diff[ROOT_WIDTH+1:0] : rem_sh[ROOT_WIDTH+1:0];
            root_reg <= {root_in[ROOT_WIDTH-2:0], take};
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

### src/aavr_div_cell.sv
`default_nettype none

// one quotient bit of a restoring divider
module aavr_div_cell #(
    parameter int DIV_WIDTH  = 33,
    parameter int QUOT_WIDTH = 31
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [DIV_WIDTH:0]    trial_in,
    input  wire logic [DIV_WIDTH-1:0]  d_in,
    input  wire logic [QUOT_WIDTH-1:0] q_in,
    output logic      [DIV_WIDTH-1:0]  rem_out,
    output logic      [DIV_WIDTH-1:0]  d_out,
    output logic      [QUOT_WIDTH-1:0] q_out
);

    logic [DIV_WIDTH-1:0]  rem_reg;
    logic [DIV_WIDTH-1:0]  d_reg;
    logic [QUOT_WIDTH-1:0] q_reg;
    logic [DIV_WIDTH:0]    diff;
    logic                  take;

    always_comb begin
        diff = trial_in - {1'b0, d_in};
        take = (trial_in >= {1'b0, d_in});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= take ? diff[DIV_WIDTH-1:0] : trial_in[DIV_WIDTH-1:0];
            d_reg   <= d_in;
            q_reg   <= {q_in[QUOT_WIDTH-2:0], take};
        end
    end

    assign rem_out = rem_reg;
    assign d_out   = d_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

### src/aavr_cordic_cell.sv
`default_nettype none

// one rotation-mode CORDIC micro-rotation
module aavr_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [aavr_pkg::CS_WIDTH-1:0] x_in,
    input  wire logic signed [aavr_pkg::CS_WIDTH-1:0] y_in,
    input  wire logic signed [aavr_pkg::CS_WIDTH-1:0] z_in,
    input  wire logic                                 flip_in,
    output logic signed      [aavr_pkg::CS_WIDTH-1:0] x_out,
    output logic signed      [aavr_pkg::CS_WIDTH-1:0] y_out,
    output logic signed      [aavr_pkg::CS_WIDTH-1:0] z_out,
    output logic                                      flip_out
);

    localparam int W = aavr_pkg::CS_WIDTH;
    localparam logic signed [W-1:0] ATAN = aavr_pkg::atan_turns(SHIFT);

    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic                flip_reg;
    logic signed [W-1:0] dx, dy;
    logic                up;

    always_comb begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        up = ~z_in[W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= up ? (x_in - dx) : (x_in + dx);
            y_reg    <= up ? (y_in + dy) : (y_in - dy);
            z_reg    <= up ? (z_in - ATAN) : (z_in + ATAN);
            flip_reg <= flip_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign flip_out = flip_reg;

endmodule

`default_nettype wire
